@@ sv/stereo_linked_rms_compressor_macros.svh @@
// Assertion macros used by the stereo compressor checker.
// No dependencies.
`ifndef STEREO_LINKED_RMS_COMPRESSOR_MACROS_SVH
`define STEREO_LINKED_RMS_COMPRESSOR_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define SLRC_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("slrc assertion failed");

// Next-cycle implication, disabled during reset.
`define SLRC_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("slrc assertion failed");

`endif

@@ sv/slrc_pkg.sv @@
// Shared constants, types and lookup tables of the stereo compressor.
// No dependencies.
package slrc_pkg;

  localparam int SAMPLE_BITS_DEF = 16;

  localparam int MUL_A_W = 33;
  localparam int MUL_B_W = 25;
  localparam int MUL_P_W = MUL_A_W + MUL_B_W;

  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_ADDR_W-1:0] REG_THRESHOLD = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_SLOPE     = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_MAKEUP    = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_ATTACK    = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] REG_RELEASE   = 3'd4;

  localparam logic [14:0] THRESHOLD_RST = 15'h6E00;  // -18 dB
  localparam logic [15:0] SLOPE_RST     = 16'd49152;
  localparam logic [12:0] MAKEUP_RST    = 13'd0;
  localparam logic [15:0] ATTACK_RST    = 16'd65399;
  localparam logic [15:0] RELEASE_RST   = 16'd65522;

  localparam logic [17:0] DB_PER_OCTAVE_Q16   = 18'd197283;
  localparam logic [13:0] LOG2_10_OVER_20_Q16 = 14'd10885;
  localparam logic [15:0] LEVEL_FLOOR_MAG     = 16'd10240;

  typedef struct packed {
    logic                      en;
    logic signed [MUL_A_W-1:0] a;
    logic signed [MUL_B_W-1:0] b;
  } mul_op_t;

  function automatic logic [16:0] log2_lut(input logic [4:0] i);
    logic [16:0] v;
    case (i)
      5'd0:    v = 17'd0;
      5'd1:    v = 17'd5732;
      5'd2:    v = 17'd11136;
      5'd3:    v = 17'd16248;
      5'd4:    v = 17'd21098;
      5'd5:    v = 17'd25711;
      5'd6:    v = 17'd30109;
      5'd7:    v = 17'd34312;
      5'd8:    v = 17'd38336;
      5'd9:    v = 17'd42196;
      5'd10:   v = 17'd45904;
      5'd11:   v = 17'd49472;
      5'd12:   v = 17'd52911;
      5'd13:   v = 17'd56229;
      5'd14:   v = 17'd59434;
      5'd15:   v = 17'd62534;
      default: v = 17'd65536;
    endcase
    return v;
  endfunction

  function automatic logic [17:0] exp2_lut(input logic [4:0] i);
    logic [17:0] v;
    case (i)
      5'd0:    v = 18'd65536;
      5'd1:    v = 18'd68438;
      5'd2:    v = 18'd71468;
      5'd3:    v = 18'd74632;
      5'd4:    v = 18'd77936;
      5'd5:    v = 18'd81386;
      5'd6:    v = 18'd84990;
      5'd7:    v = 18'd88752;
      5'd8:    v = 18'd92682;
      5'd9:    v = 18'd96785;
      5'd10:   v = 18'd101070;
      5'd11:   v = 18'd105545;
      5'd12:   v = 18'd110218;
      5'd13:   v = 18'd115098;
      5'd14:   v = 18'd120194;
      5'd15:   v = 18'd125515;
      default: v = 18'd131072;
    endcase
    return v;
  endfunction

endpackage

@@ sv/slrc_mul.sv @@
// Shared signed multiplier with registered product.
// Depends on slrc_pkg.
module slrc_mul (
  input  logic                                 clk,
  input  slrc_pkg::mul_op_t                    op,
  output logic signed [slrc_pkg::MUL_P_W-1:0]  prod
);

  logic signed [slrc_pkg::MUL_P_W-1:0] prod_r;

  always_ff @(posedge clk) begin
    if (op.en) begin
      prod_r <= op.a * op.b;
    end
  end

  assign prod = prod_r;

endmodule

@@ sv/stereo_linked_rms_compressor.sv @@
// Stereo-linked feed-forward RMS compressor, top level.
// One stereo pair at a time: each takes 11 multiplies through the shared
// multiplier plus a 5-step leading-one search, and the next pair is accepted
// only after the result is loaded into the output register.
// Input ready only when the sequencer is idle; output held in a register.
// rst_n (sync, active low) clears sequencer, energy, out valid; sets config defaults.
module stereo_linked_rms_compressor #(
  parameter int SAMPLE_BITS = slrc_pkg::SAMPLE_BITS_DEF,
  localparam int IN_W  = ((2 * SAMPLE_BITS + 7) / 8) * 8,
  localparam int OUT_W = ((2 * SAMPLE_BITS + 16 + 7) / 8) * 8
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [IN_W-1:0]                   in_tdata,   // left_in, right_in
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [OUT_W-1:0]                  out_tdata,  // left_out, right_out, applied_gain
  input  logic                              cfg_wr_en,
  input  logic [slrc_pkg::CFG_ADDR_W-1:0]   cfg_addr,
  input  logic [slrc_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

  localparam int SB  = SAMPLE_BITS;
  localparam int FB  = 2 * SB - 1;
  localparam int TSR = (FB >= 30) ? FB - 30 : 0;
  localparam int TSL = (FB >= 30) ? 0 : 30 - FB;
  localparam int AW  = slrc_pkg::MUL_A_W;
  localparam int BW  = slrc_pkg::MUL_B_W;
  localparam int PW  = slrc_pkg::MUL_P_W;
  localparam longint YHI = (64'sd1 <<< (SB - 1)) - 64'sd1;
  localparam longint YLO = -YHI - 64'sd1;

  typedef enum logic [19:0] {
    S_IDLE = 20'h00001,
    S_SQL  = 20'h00002,
    S_SQR  = 20'h00004,
    S_TGT  = 20'h00008,
    S_EM2  = 20'h00010,
    S_EUPD = 20'h00020,
    S_NORM = 20'h00040,
    S_LOGM = 20'h00080,
    S_LOGS = 20'h00100,
    S_DBM  = 20'h00200,
    S_DBS  = 20'h00400,
    S_REDM = 20'h00800,
    S_REDS = 20'h01000,
    S_XM   = 20'h02000,
    S_XS   = 20'h04000,
    S_EXM  = 20'h08000,
    S_EXS  = 20'h10000,
    S_GL   = 20'h20000,
    S_GR   = 20'h40000,
    S_DONE = 20'h80000
  } state_t;

  state_t state_r, state_nxt;

  logic [14:0] thr_r;
  logic [15:0] slope_r;
  logic [12:0] makeup_r;
  logic [15:0] atk_r;
  logic [15:0] rel_r;

  logic signed [SB-1:0] l_r, l_nxt, r_r, r_nxt;
  logic [2*SB-1:0]      sq_r, sq_nxt;
  logic [30:0]          tgt_r, tgt_nxt;
  logic [15:0]          c_r, c_nxt;
  logic [47:0]          acc_r, acc_nxt;
  logic [31:0]          e_r, e_nxt;
  logic [31:0]          norm_r, norm_nxt;
  logic [4:0]           p_r, p_nxt;
  logic [2:0]           cnt_r, cnt_nxt;
  logic                 ezero_r, ezero_nxt;
  logic [20:0]          neglog_r, neglog_nxt;
  logic signed [16:0]   over_r, over_nxt;
  logic signed [17:0]   gdb_r, gdb_nxt;
  logic signed [23:0]   x_r, x_nxt;
  logic [15:0]          gain_r, gain_nxt;
  logic [SB-1:0]        outl_r, outl_nxt;
  logic                 oval_r, oval_nxt;
  logic [OUT_W-1:0]     odata_r, odata_nxt;

  slrc_pkg::mul_op_t    op;
  logic signed [PW-1:0] prod;

  slrc_mul u_mul (
    .clk  (clk),
    .op   (op),
    .prod (prod)
  );

  function automatic logic [SB-1:0] sat_scale(input logic signed [PW-1:0] p);
    logic signed [PW-1:0] y;
    logic [SB-1:0]        v;
    y = p >>> 12;
    if (64'(y) > YHI) begin
      v = SB'(YHI);
    end else if (64'(y) < YLO) begin
      v = SB'(YLO);
    end else begin
      v = y[SB-1:0];
    end
    return v;
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r    <= slrc_pkg::THRESHOLD_RST;
      slope_r  <= slrc_pkg::SLOPE_RST;
      makeup_r <= slrc_pkg::MAKEUP_RST;
      atk_r    <= slrc_pkg::ATTACK_RST;
      rel_r    <= slrc_pkg::RELEASE_RST;
    end else if (cfg_wr_en) begin
      case (cfg_addr)
        slrc_pkg::REG_THRESHOLD: thr_r    <= cfg_wdata[14:0];
        slrc_pkg::REG_SLOPE:     slope_r  <= cfg_wdata;
        slrc_pkg::REG_MAKEUP:    makeup_r <= cfg_wdata[12:0];
        slrc_pkg::REG_ATTACK:    atk_r    <= cfg_wdata;
        slrc_pkg::REG_RELEASE:   rel_r    <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    logic [2*SB:0]        sum;
    logic [63:0]          sum64;
    logic [48:0]          esum;
    logic [5:0]           step;
    logic [16:0]          frac;
    logic signed [23:0]   nl;
    logic [39:0]          qsum;
    logic [15:0]          q;
    logic signed [17:0]   lvl;
    logic signed [17:0]   ov;
    logic [15:0]          red;
    logic [17:0]          mant;
    logic signed [7:0]    n;
    logic [7:0]           sh;
    logic [20:0]          gp;
    logic [4:0]           ix;

    state_nxt  = state_r;
    l_nxt      = l_r;
    r_nxt      = r_r;
    sq_nxt     = sq_r;
    tgt_nxt    = tgt_r;
    c_nxt      = c_r;
    acc_nxt    = acc_r;
    e_nxt      = e_r;
    norm_nxt   = norm_r;
    p_nxt      = p_r;
    cnt_nxt    = cnt_r;
    ezero_nxt  = ezero_r;
    neglog_nxt = neglog_r;
    over_nxt   = over_r;
    gdb_nxt    = gdb_r;
    x_nxt      = x_r;
    gain_nxt   = gain_r;
    outl_nxt   = outl_r;
    oval_nxt   = oval_r;
    odata_nxt  = odata_r;
    op.en      = 1'b0;
    op.a       = '0;
    op.b       = '0;

    sum   = '0;
    sum64 = '0;
    esum  = '0;
    step  = '0;
    frac  = '0;
    nl    = '0;
    qsum  = '0;
    q     = '0;
    lvl   = '0;
    ov    = '0;
    red   = '0;
    mant  = '0;
    n     = '0;
    sh    = '0;
    gp    = '0;
    ix    = '0;

    if (oval_r && out_tready) begin
      oval_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          l_nxt     = in_tdata[SB-1:0];
          r_nxt     = in_tdata[2*SB-1:SB];
          state_nxt = S_SQL;
        end
      end
      S_SQL: begin
        op.en     = 1'b1;
        op.a      = {{(AW-SB){l_r[SB-1]}}, l_r};
        op.b      = {{(BW-SB){l_r[SB-1]}}, l_r};
        state_nxt = S_SQR;
      end
      S_SQR: begin
        sq_nxt    = prod[2*SB-1:0];
        op.en     = 1'b1;
        op.a      = {{(AW-SB){r_r[SB-1]}}, r_r};
        op.b      = {{(BW-SB){r_r[SB-1]}}, r_r};
        state_nxt = S_TGT;
      end
      S_TGT: begin
        sum     = {1'b0, sq_r} + {1'b0, prod[2*SB-1:0]};
        sum64   = 64'(sum);
        tgt_nxt = 31'((sum64 >> TSR) << TSL);
        c_nxt   = ({1'b0, tgt_nxt} > e_r) ? atk_r : rel_r;
        op.en   = 1'b1;
        op.a    = {1'b0, e_r};
        op.b    = {{(BW-16){1'b0}}, c_nxt};
        state_nxt = S_EM2;
      end
      S_EM2: begin
        acc_nxt   = prod[47:0];
        op.en     = 1'b1;
        op.a      = {2'b0, tgt_r};
        op.b      = {{(BW-17){1'b0}}, 17'h10000 - {1'b0, c_r}};
        state_nxt = S_EUPD;
      end
      S_EUPD: begin
        esum      = {1'b0, acc_r} + prod[48:0];
        e_nxt     = esum[47:16];
        norm_nxt  = e_nxt;
        p_nxt     = 5'd31;
        cnt_nxt   = 3'd0;
        ezero_nxt = (e_nxt == 32'd0);
        state_nxt = S_NORM;
      end
      S_NORM: begin
        case (cnt_r)
          3'd0:    step = 6'd16;
          3'd1:    step = 6'd8;
          3'd2:    step = 6'd4;
          3'd3:    step = 6'd2;
          default: step = 6'd1;
        endcase
        if ((norm_r >> (6'd32 - step)) == 32'd0) begin
          norm_nxt = norm_r << step;
          p_nxt    = p_r - step[4:0];
        end
        cnt_nxt = cnt_r + 3'd1;
        if (cnt_r == 3'd4) begin
          state_nxt = S_LOGM;
        end
      end
      S_LOGM: begin
        ix        = {1'b0, norm_r[30:27]};
        op.en     = 1'b1;
        op.a      = {{(AW-17){1'b0}},
                     slrc_pkg::log2_lut(ix + 5'd1) - slrc_pkg::log2_lut(ix)};
        op.b      = {{(BW-16){1'b0}}, norm_r[26:11]};
        state_nxt = S_LOGS;
      end
      S_LOGS: begin
        ix   = {1'b0, norm_r[30:27]};
        frac = slrc_pkg::log2_lut(ix) + prod[32:16];
        nl   = ((24'sd30 - $signed({19'd0, p_r})) <<< 16) - $signed({7'd0, frac});
        neglog_nxt = (nl < 24'sd0) ? 21'd0 : nl[20:0];
        state_nxt  = S_DBM;
      end
      S_DBM: begin
        op.en     = 1'b1;
        op.a      = {{(AW-21){1'b0}}, neglog_r};
        op.b      = {{(BW-18){1'b0}}, slrc_pkg::DB_PER_OCTAVE_Q16};
        state_nxt = S_DBS;
      end
      S_DBS: begin
        qsum = prod[39:0] + 40'h0000800000;
        q    = qsum[39:24];
        if (ezero_r || q > slrc_pkg::LEVEL_FLOOR_MAG) begin
          q = slrc_pkg::LEVEL_FLOOR_MAG;
        end
        lvl       = -$signed({2'b0, q});
        ov        = lvl - 18'(signed'(thr_r));
        over_nxt  = ov[16:0];
        state_nxt = S_REDM;
      end
      S_REDM: begin
        op.en     = 1'b1;
        op.a      = {{(AW-17){over_r[16]}}, over_r};
        op.b      = {{(BW-16){1'b0}}, slope_r};
        state_nxt = S_REDS;
      end
      S_REDS: begin
        if (over_r > 17'sd0 && slope_r != 16'd0) begin
          red = prod[31:16];
        end
        gdb_nxt   = $signed({5'd0, makeup_r}) - $signed({2'd0, red});
        state_nxt = S_XM;
      end
      S_XM: begin
        op.en     = 1'b1;
        op.a      = {{(AW-18){gdb_r[17]}}, gdb_r};
        op.b      = {{(BW-14){1'b0}}, slrc_pkg::LOG2_10_OVER_20_Q16};
        state_nxt = S_XS;
      end
      S_XS: begin
        x_nxt     = prod[31:8];
        state_nxt = S_EXM;
      end
      S_EXM: begin
        ix        = {1'b0, x_r[15:12]};
        op.en     = 1'b1;
        op.a      = {{(AW-18){1'b0}},
                     slrc_pkg::exp2_lut(ix + 5'd1) - slrc_pkg::exp2_lut(ix)};
        op.b      = {{(BW-12){1'b0}}, x_r[11:0]};
        state_nxt = S_EXS;
      end
      S_EXS: begin
        ix   = {1'b0, x_r[15:12]};
        mant = slrc_pkg::exp2_lut(ix) + prod[29:12];
        n    = x_r[23:16];
        if (n >= 8'sd4) begin
          gain_nxt = 16'hFFFF;
        end else if (n >= 8'sd0) begin
          gp       = ({3'd0, mant} << n[1:0]) >> 4;
          gain_nxt = (gp > 21'd65535) ? 16'hFFFF : gp[15:0];
        end else begin
          sh       = 8'd4 - n;
          gp       = {3'd0, mant} >> sh;
          gain_nxt = gp[15:0];
        end
        state_nxt = S_GL;
      end
      S_GL: begin
        op.en     = 1'b1;
        op.a      = {{(AW-16){1'b0}}, gain_r};
        op.b      = {{(BW-SB){l_r[SB-1]}}, l_r};
        state_nxt = S_GR;
      end
      S_GR: begin
        outl_nxt  = sat_scale(prod);
        op.en     = 1'b1;
        op.a      = {{(AW-16){1'b0}}, gain_r};
        op.b      = {{(BW-SB){r_r[SB-1]}}, r_r};
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (!oval_r || out_tready) begin
          oval_nxt  = 1'b1;
          odata_nxt = OUT_W'({gain_r, sat_scale(prod), outl_r});
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      e_r     <= '0;
      oval_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      e_r     <= e_nxt;
      oval_r  <= oval_nxt;
    end
  end

  always_ff @(posedge clk) begin
    l_r      <= l_nxt;
    r_r      <= r_nxt;
    sq_r     <= sq_nxt;
    tgt_r    <= tgt_nxt;
    c_r      <= c_nxt;
    acc_r    <= acc_nxt;
    norm_r   <= norm_nxt;
    p_r      <= p_nxt;
    cnt_r    <= cnt_nxt;
    ezero_r  <= ezero_nxt;
    neglog_r <= neglog_nxt;
    over_r   <= over_nxt;
    gdb_r    <= gdb_nxt;
    x_r      <= x_nxt;
    gain_r   <= gain_nxt;
    outl_r   <= outl_nxt;
    odata_r  <= odata_nxt;
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = oval_r;
  assign out_tdata  = odata_r;

endmodule

@@ sv/slrc_checker.sv @@
// Port-level checker for the stereo compressor, bound to the top level.
// Depends on slrc_pkg and stereo_linked_rms_compressor_macros.svh.
`include "stereo_linked_rms_compressor_macros.svh"

module slrc_checker #(
  parameter int SAMPLE_BITS = slrc_pkg::SAMPLE_BITS_DEF,
  localparam int OUT_W = ((2 * SAMPLE_BITS + 16 + 7) / 8) * 8
) (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_tvalid,
  input logic                            in_tready,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [OUT_W-1:0]                out_tdata
);

  logic in_xfer;
  assign in_xfer = in_tvalid && in_tready;

  `SLRC_ASSERT_NXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid)
  `SLRC_ASSERT_NXT(a_out_stable, clk, rst_n, out_tvalid && !out_tready, $stable(out_tdata))
  `SLRC_ASSERT_NXT(a_busy_after_in, clk, rst_n, in_xfer, !in_tready)
  `SLRC_ASSERT_IMP(a_result_from_busy, clk, rst_n, $rose(out_tvalid), $past(!in_tready))

endmodule

bind stereo_linked_rms_compressor slrc_checker #(
  .SAMPLE_BITS (SAMPLE_BITS)
) u_slrc_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

@@ tb/stereo_linked_rms_compressor_test.sv @@
// Testbench for stereo_linked_rms_compressor: streams stereo pairs, predicts
// gain and scaled samples with a bit-exact model, checks every output transfer.
// Depends on slrc_pkg and the compressor RTL.
module stereo_linked_rms_compressor_test;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic signed [15:0] left;
    logic signed [15:0] right;
    logic [15:0]        gain;
  } comp_result_t;

  class comp_scoreboard;
    logic [14:0] threshold;
    logic [15:0] slope;
    logic [12:0] makeup;
    logic [15:0] attack;
    logic [15:0] rel;
    logic [31:0] energy;
    comp_result_t pending[$];
    int errors;

    function void reset_state();
      threshold = slrc_pkg::THRESHOLD_RST;
      slope = slrc_pkg::SLOPE_RST;
      makeup = slrc_pkg::MAKEUP_RST;
      attack = slrc_pkg::ATTACK_RST;
      rel = slrc_pkg::RELEASE_RST;
      energy = 0;
      errors = 0;
    endfunction

    function void write_reg(logic [slrc_pkg::CFG_ADDR_W-1:0] idx, logic [15:0] val);
      case (idx)
        slrc_pkg::REG_THRESHOLD: threshold = val[14:0];
        slrc_pkg::REG_SLOPE:     slope = val;
        slrc_pkg::REG_MAKEUP:    makeup = val[12:0];
        slrc_pkg::REG_ATTACK:    attack = val;
        slrc_pkg::REG_RELEASE:   rel = val;
        default: ;
      endcase
    endfunction

    function longint level_of(logic [31:0] e);
      int p;
      longint norm, idx, f, frac, neglog, lvl, lo, hi;
      if (e == 0) return -10240;
      p = 0;
      while (p < 31 && (e >> (p + 1)) != 0) p++;
      norm = (longint'(e) << (31 - p)) & 64'hFFFF_FFFF;
      idx = (norm >> 27) & 15;
      f = (norm >> 11) & 16'hFFFF;
      lo = log2_tab(idx);
      hi = log2_tab(idx + 1);
      frac = lo + (((hi - lo) * f) >> 16);
      neglog = (30 - p) * 65536 - frac;
      if (neglog < 0) neglog = 0;
      lvl = -((neglog * 197283 + (64'd1 << 23)) >> 24);
      if (lvl < -10240) lvl = -10240;
      return lvl;
    endfunction

    function longint log2_tab(longint i);
      longint t[17] = '{0, 5732, 11136, 16248, 21098, 25711, 30109, 34312, 38336,
                        42196, 45904, 49472, 52911, 56229, 59434, 62534, 65536};
      return t[i];
    endfunction

    function longint exp2_tab(longint i);
      longint t[17] = '{65536, 68438, 71468, 74632, 77936, 81386, 84990, 88752,
                        92682, 96785, 101070, 105545, 110218, 115098, 120194,
                        125515, 131072};
      return t[i];
    endfunction

    function longint floor_div(longint v, int sh);
      return v >>> sh;
    endfunction

    function logic [15:0] gain_of(longint g);
      longint x, n, fp, i, f, mant, gn;
      x = floor_div(g * 10885, 8);
      n = floor_div(x, 16);
      fp = x - n * 65536;
      i = (fp >> 12) & 15;
      f = fp & 12'hFFF;
      mant = exp2_tab(i) + (((exp2_tab(i + 1) - exp2_tab(i)) * f) >> 12);
      if (n >= 4) return 16'hFFFF;
      if (n >= 0) gn = (mant << n) >> 4;
      else begin
        if (4 - n > 40) return 0;
        gn = mant >> (4 - n);
      end
      return (gn > 65535) ? 16'hFFFF : gn[15:0];
    endfunction

    function logic [15:0] scale(longint s, logic [15:0] g);
      longint y;
      y = floor_div(s * longint'(g), 12);
      if (y > 32767) y = 32767;
      if (y < -32768) y = -32768;
      return y[15:0];
    endfunction

    function void note_input(logic signed [15:0] l, logic signed [15:0] r);
      longint ll, rr, target, c, lvl, over, red;
      comp_result_t res;
      ll = l;
      rr = r;
      target = (ll * ll + rr * rr) >> 1;
      c = (target > longint'(energy)) ? attack : rel;
      energy = (c * energy + (65536 - c) * target) >> 16;
      lvl = level_of(energy);
      over = lvl - longint'($signed(threshold));
      red = 0;
      if (slope != 0 && over > 0) red = (over * slope) >> 16;
      res.gain = gain_of(longint'(makeup) - red);
      res.left = scale(ll, res.gain);
      res.right = scale(rr, res.gain);
      pending.push_back(res);
    endfunction

    function void check_result(logic [47:0] data);
      comp_result_t want, got;
      got.left = data[15:0];
      got.right = data[31:16];
      got.gain = data[47:32];
      if (pending.size() == 0) begin
        $display("%0t: unexpected output transfer %h", $time, data);
        errors++;
        return;
      end
      want = pending.pop_front();
      if (got.left !== want.left)
        $display("%0t: left_out expected %0d actual %0d", $time, want.left, got.left);
      if (got.right !== want.right)
        $display("%0t: right_out expected %0d actual %0d", $time, want.right, got.right);
      if (got.gain !== want.gain)
        $display("%0t: applied_gain expected %0d actual %0d", $time, want.gain, got.gain);
      if (got !== want) errors++;
    endfunction
  endclass

  logic clk = 0;
  logic rst_n = 0;
  logic in_tvalid = 0;
  logic in_tready;
  logic [31:0] in_tdata = 0;
  logic out_tvalid;
  logic out_tready = 0;
  logic [47:0] out_tdata;
  logic cfg_wr_en = 0;
  logic [slrc_pkg::CFG_ADDR_W-1:0] cfg_addr = slrc_pkg::REG_THRESHOLD;
  logic [slrc_pkg::CFG_DATA_W-1:0] cfg_wdata = 0;

  comp_scoreboard sb;
  int idle_cycles = 0;

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  stereo_linked_rms_compressor DUT (.*);

  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) sb.note_input(in_tdata[15:0], in_tdata[31:16]);
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata);
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 2000) begin
      $display("FAILURE");
      $finish;
    end
  end

  // receiver with random stalls
  initial begin
    int w;
    forever begin
      @(negedge clk);
      w = $urandom_range(0, 3);
      if ($urandom_range(0, 3) == 0) w = 0;
      if (w > 0) begin
        out_tready <= 0;
        repeat (w) @(negedge clk);
      end
      out_tready <= 1;
      do @(posedge clk); while (!(out_tvalid && out_tready));
    end
  end

  task automatic write_reg(logic [slrc_pkg::CFG_ADDR_W-1:0] idx, logic [15:0] val);
    @(negedge clk);
    cfg_wr_en <= 1;
    cfg_addr <= idx;
    cfg_wdata <= val;
    sb.write_reg(idx, val);
    @(negedge clk);
    cfg_wr_en <= 0;
  endtask

  task automatic send_pair(logic [15:0] l, logic [15:0] r, bit no_gap);
    int w;
    w = no_gap ? 0 : $urandom_range(0, 3);
    repeat (w + 1) @(negedge clk);
    in_tdata <= {r, l};
    in_tvalid <= 1;
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
    in_tvalid <= 0;
  endtask

  task automatic drain();
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic random_pairs(int count);
    logic [15:0] l, r;
    int amp;
    bit burst;
    burst = $urandom_range(0, 1);
    repeat (count) begin
      amp = $urandom_range(0, 15);
      l = 16'($urandom_range(0, 65535));
      r = 16'($urandom_range(0, 65535));
      if (amp < 10) begin
        l = $signed(l) >>> $urandom_range(0, 12);
        r = $signed(r) >>> $urandom_range(0, 12);
      end
      send_pair(l, r, burst);
    end
  endtask

  initial begin
    sb = new();
    sb.reset_state();
    repeat (6) @(negedge clk);
    rst_n <= 1;

    // directed: extremes, silence, full scale, sign combinations
    send_pair(16'h0000, 16'h0000, 0);
    send_pair(16'h7FFF, 16'h7FFF, 0);
    send_pair(16'h8000, 16'h8000, 1);
    send_pair(16'h8000, 16'h7FFF, 0);
    send_pair(16'h0001, 16'hFFFF, 0);
    send_pair(16'h4000, 16'h0000, 0);
    send_pair(16'h0000, 16'hC000, 0);
    drain();

    // instant detector, hard compression, high threshold out of range
    write_reg(slrc_pkg::REG_ATTACK, 16'd0);
    write_reg(slrc_pkg::REG_RELEASE, 16'd0);
    write_reg(slrc_pkg::REG_SLOPE, 16'hFFFF);
    write_reg(slrc_pkg::REG_THRESHOLD, 16'h7FFF);
    write_reg(slrc_pkg::REG_MAKEUP, 16'd6144);
    send_pair(16'h7FFF, 16'h8000, 0);
    send_pair(16'h0100, 16'h0100, 0);
    send_pair(16'h0000, 16'h0000, 0);
    drain();
    write_reg(slrc_pkg::REG_THRESHOLD, 16'h4400);  // -60 dB
    write_reg(slrc_pkg::REG_MAKEUP, 16'h1FFF);     // gain overflow
    send_pair(16'h7FFF, 16'h8000, 0);
    send_pair(16'h0010, 16'hFFF0, 0);
    send_pair(16'h0000, 16'h0000, 0);
    drain();
    write_reg(slrc_pkg::REG_MAKEUP, 16'd0);
    send_pair(16'h7FFF, 16'h7FFF, 0);    // very low gain
    drain();
    write_reg(slrc_pkg::REG_SLOPE, 16'd0);
    send_pair(16'h7FFF, 16'h8000, 0);    // zero slope
    drain();

    // random phases across settings
    for (int ph = 0; ph < 8; ph++) begin
      write_reg(slrc_pkg::REG_THRESHOLD, ph == 0 ? 16'h4400 : (ph == 1 ? 16'h0000 :
                16'($urandom_range(0, 15360) * -1)));
      write_reg(slrc_pkg::REG_SLOPE, ph == 2 ? 16'hFFFF : 16'($urandom_range(0, 65535)));
      write_reg(slrc_pkg::REG_MAKEUP, ph == 3 ? 16'd6144 : 16'($urandom_range(0, 6144)));
      write_reg(slrc_pkg::REG_ATTACK, ph == 4 ? 16'hFFFF : 16'($urandom_range(0, 65535)));
      write_reg(slrc_pkg::REG_RELEASE,
                ph == 5 ? 16'hFFFF : 16'($urandom_range(60000, 65535)));
      if (ph == 6) begin
        write_reg(slrc_pkg::REG_ATTACK, slrc_pkg::ATTACK_RST);
        write_reg(slrc_pkg::REG_RELEASE, slrc_pkg::RELEASE_RST);
      end
      random_pairs(72);
      drain();
    end

    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end
endmodule

@@ files.f @@
+incdir+sv
sv/slrc_pkg.sv
sv/slrc_mul.sv
sv/stereo_linked_rms_compressor.sv
sv/slrc_checker.sv
tb/stereo_linked_rms_compressor_test.sv
